### rtl/gsip_pkg.sv
`timescale 1ns / 1ps

package gsip_pkg;

  localparam int TEMP_W  = 20;
  localparam int ERR_W   = 21;
  localparam int PWR_W   = 28;
  localparam int LIM_W   = 24;
  localparam int ALPHA_W = 9;
  localparam int CNT_W   = 8;
  localparam int ITER_W  = 24;
  localparam int ZONE_W  = 2;
  localparam int ROT_W   = 2;
  localparam int DTERM_W = 32;
  localparam int ACC_W   = 40;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 28;

  localparam logic [CFG_AW-1:0] CFG_TARGET_TEMP  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_START_POWER  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_STEP_LIMIT   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MIN_POWER    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_D_ALPHA      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_ROT_ENABLE   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_ROT_SUSPEND  = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_ROT_NEED     = 3'd7;

  localparam logic [TEMP_W-1:0]  TARGET_RST      = 20'd431360;
  localparam logic [PWR_W-1:0]   START_POWER_RST = 28'd4000000;
  localparam logic [LIM_W-1:0]   STEP_LIMIT_RST  = 24'd80000;
  localparam logic [PWR_W-1:0]   MIN_POWER_RST   = 28'd800000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = 9'd77;
  localparam logic [TEMP_W-1:0]  ROT_ENABLE_RST  = 20'd2560;
  localparam logic [TEMP_W-1:0]  ROT_SUSPEND_RST = 20'd12800;
  localparam logic [CNT_W-1:0]   ROT_NEED_RST    = 8'd50;
  localparam logic [TEMP_W-1:0]  HELD_AE_RST     = 20'd255744;

  localparam logic [PWR_W-1:0]   P_MAX    = 28'hFFFFFFF;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  localparam logic [TEMP_W-1:0] T_Z1   = 20'd25600;
  localparam logic [TEMP_W-1:0] T_Z2   = 20'd5120;
  localparam logic [TEMP_W-1:0] T_Z3   = 20'd1280;
  localparam logic [TEMP_W-1:0] T_HYST = 20'd256;
  localparam logic [TEMP_W-1:0] T_Z1H  = T_Z1 + T_HYST;
  localparam logic [TEMP_W-1:0] T_Z2H  = T_Z2 + T_HYST;
  localparam logic [TEMP_W-1:0] T_Z3H  = T_Z3 + T_HYST;

  // ceil(2^32 / 5): exact quotient for dividends below 2^30
  localparam logic [MUL_W-1:0] RECIP5 = 33'h033333334;

  localparam logic [ZONE_W-1:0] ZONE_COARSE     = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_TRANSITION = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_FINE       = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_PRECISION  = 2'd3;

  localparam logic [ROT_W-1:0] ROT_OFF     = 2'd0;
  localparam logic [ROT_W-1:0] ROT_ON      = 2'd1;
  localparam logic [ROT_W-1:0] ROT_SUSPEND = 2'd2;

  function automatic logic [8:0] kp_of(input logic [ZONE_W-1:0] z);
    logic [8:0] k;
    unique case (z)
      ZONE_COARSE:     k = 9'd400;
      ZONE_TRANSITION: k = 9'd500;
      ZONE_FINE:       k = 9'd400;
      ZONE_PRECISION:  k = 9'd150;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] ki_of(input logic [ZONE_W-1:0] z);
    logic [4:0] k;
    unique case (z)
      ZONE_COARSE:     k = 5'd15;
      ZONE_TRANSITION: k = 5'd20;
      ZONE_FINE:       k = 5'd12;
      ZONE_PRECISION:  k = 5'd5;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] kd_of(input logic [ZONE_W-1:0] z);
    logic [6:0] k;
    unique case (z)
      ZONE_COARSE:     k = 7'd30;
      ZONE_TRANSITION: k = 7'd60;
      ZONE_FINE:       k = 7'd80;
      ZONE_PRECISION:  k = 7'd40;
    endcase
    return k;
  endfunction

  // 16 is 1 mod 5, so the nibble sum keeps the residue
  function automatic logic mod5_zero(input logic [ITER_W-1:0] v);
    logic [6:0] s;
    logic [4:0] f;
    s = '0;
    for (int i = 0; i < ITER_W / 4; i++) begin
      s = s + 7'(v[4*i +: 4]);
    end
    f = 5'(s[6:4]) + 5'(s[3:0]);
    return (f == 5'd0) || (f == 5'd5) || (f == 5'd10) || (f == 5'd15) || (f == 5'd20);
  endfunction

  function automatic logic [ZONE_W-1:0] pick_zone(input logic [TEMP_W-1:0] ae,
                                                 input logic valid,
                                                 input logic [ZONE_W-1:0] prev);
    logic [ZONE_W-1:0] z;
    if (!valid) begin
      if (ae > T_Z1)      z = ZONE_COARSE;
      else if (ae > T_Z2) z = ZONE_TRANSITION;
      else if (ae > T_Z3) z = ZONE_FINE;
      else                z = ZONE_PRECISION;
    end else begin
      unique case (prev)
        ZONE_COARSE: begin
          z = (ae <= T_Z1) ? ZONE_TRANSITION : ZONE_COARSE;
        end
        ZONE_TRANSITION: begin
          if (ae > T_Z1H)      z = ZONE_COARSE;
          else if (ae <= T_Z2) z = ZONE_FINE;
          else                 z = ZONE_TRANSITION;
        end
        ZONE_FINE: begin
          if (ae > T_Z2H)      z = ZONE_TRANSITION;
          else if (ae <= T_Z3) z = ZONE_PRECISION;
          else                 z = ZONE_FINE;
        end
        ZONE_PRECISION: begin
          z = (ae > T_Z3H) ? ZONE_FINE : ZONE_PRECISION;
        end
      endcase
    end
    return z;
  endfunction

endpackage

### rtl/gsip_mul.sv
`timescale 1ns / 1ps

module gsip_mul
  import gsip_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### rtl/gain_scheduled_incremental_pid_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat fields
// in_      in   tdata: iteration, measured_temp; tuser: area_valid
// out_     out  tdata: power_total .. abs_error; tuser: updated
// cfg_     in   we, addr (register index), wdata
//
// An iteration that updates the PID passes through the gate, M1 to M6, apply,
// split and done states; one that skips the update goes from gate to split and
// done. One 33x33 multiplier is shared by every product, including the 4/5
// power split. in_tready is high only when the sequencer is idle. A result
// waits in the output register while the next beat is taken. Reset (rst_n low,
// synchronous) restores the register values and the controller state at once.
module gain_scheduled_incremental_pid_unit
  import gsip_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,   // iteration[23:0], measured_temp[43:24], zero pad
  input  logic                in_tuser,   // area_valid
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [119:0]        out_tdata,  // power_total, power_main, power_bottom, gain_zone,
                                          // step_clipped, rotation_mode, stable_count,
                                          // abs_error, zero pad
  output logic                out_tuser,  // updated
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GATE  = 4'd1;
  localparam logic [3:0] S_M1    = 4'd2;
  localparam logic [3:0] S_M2    = 4'd3;
  localparam logic [3:0] S_M3    = 4'd4;
  localparam logic [3:0] S_M4    = 4'd5;
  localparam logic [3:0] S_M5    = 4'd6;
  localparam logic [3:0] S_M6    = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_SPLIT = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r;

  logic [TEMP_W-1:0]  target_r, rot_enable_r, rot_suspend_r;
  logic [PWR_W-1:0]   start_power_r, min_power_r;
  logic [LIM_W-1:0]   step_limit_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [CNT_W-1:0]   rot_need_r;

  logic [PWR_W-1:0]          power_now_r;
  logic signed [ERR_W-1:0]   err_last_r, err_before_r;
  logic signed [DTERM_W-1:0] dterm_r;
  logic                      has_updated_r;
  logic                      zone_valid_r;
  logic [ZONE_W-1:0]         last_zone_r;
  logic [ROT_W-1:0]          rot_state_r;
  logic [CNT_W-1:0]          rot_counter_r;
  logic [TEMP_W-1:0]         held_ae_r;

  logic [ITER_W-1:0]         iter_r;
  logic [TEMP_W-1:0]         meas_r;
  logic                      av_r;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [ERR_W:0]     de1_r;
  logic signed [ERR_W+1:0]   dd_r;
  logic [ZONE_W-1:0]         zone_r;
  logic                      updated_r, clipped_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DTERM_W-1:0] td_r;

  logic          out_valid_r;
  logic [119:0]  out_tdata_r;
  logic          out_tuser_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_lo;

  gsip_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign prod_lo = prod_r[ACC_W-1:0];

  logic [ALPHA_W-1:0] alpha_c, alpha_inv;
  assign alpha_c   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_inv = ALPHA_ONE - alpha_c;

  // gate step
  logic signed [ERR_W-1:0] e_raw, e_c, el_c, ebl_c;
  logic [ERR_W-1:0]        ae_full;
  logic [TEMP_W-1:0]       ae_c;
  logic [ZONE_W-1:0]       zone_c;
  logic                    gate5_c, do_pid_c;
  logic signed [ERR_W:0]   de1_c, de2_c;

  assign e_raw   = $signed({1'b0, target_r}) - $signed({1'b0, meas_r});
  assign e_c     = av_r ? e_raw : '0;
  assign ae_full = e_c[ERR_W-1] ? ERR_W'(-e_c) : ERR_W'(e_c);
  assign ae_c    = ae_full[TEMP_W-1:0];
  assign zone_c  = pick_zone(ae_c, zone_valid_r, last_zone_r);
  assign gate5_c = (iter_r != '0) && mod5_zero(iter_r);
  assign do_pid_c = gate5_c && av_r && ((zone_c == ZONE_PRECISION) || !iter_r[0]);
  assign el_c    = has_updated_r ? err_last_r : e_c;
  assign ebl_c   = has_updated_r ? err_before_r : e_c;
  assign de1_c   = {e_c[ERR_W-1], e_c} - {el_c[ERR_W-1], el_c};
  assign de2_c   = {el_c[ERR_W-1], el_c} - {ebl_c[ERR_W-1], ebl_c};

  // accumulate / filter
  logic signed [ACC_W-1:0] acc_sum, td_full;
  assign acc_sum = acc_r + prod_lo;
  assign td_full = (acc_sum + 40'sd128) >>> 8;

  // apply step
  logic signed [ACC_W-1:0] lim16, dpr_round;
  logic signed [25:0]      dpo;
  logic                    clip_c;
  logic signed [29:0]      np_raw;
  logic [PWR_W-1:0]        np_c;
  logic [CNT_W:0]          cnt_inc;

  assign lim16     = $signed({12'b0, step_limit_r, 4'b0});
  assign dpr_round = (acc_r + 40'sd8) >>> 4;

  always_comb begin
    clip_c = 1'b1;
    priority if (acc_r > lim16) begin
      dpo = $signed({2'b0, step_limit_r});
    end else if (acc_r < -lim16) begin
      dpo = -$signed({2'b0, step_limit_r});
    end else begin
      dpo    = dpr_round[25:0];
      clip_c = 1'b0;
    end
  end

  assign np_raw = $signed({2'b0, power_now_r}) + {{4{dpo[25]}}, dpo};

  always_comb begin
    priority if (np_raw < $signed({2'b0, min_power_r})) begin
      np_c = min_power_r;
    end else if (np_raw > $signed({2'b0, P_MAX})) begin
      np_c = P_MAX;
    end else begin
      np_c = np_raw[PWR_W-1:0];
    end
  end

  assign cnt_inc = {1'b0, rot_counter_r} + 9'd1;

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      S_M1: begin
        mul_a = {26'b0, kd_of(zone_r)};
        mul_b = {{10{dd_r[ERR_W+1]}}, dd_r};
      end
      S_M2: begin
        mul_a = {24'b0, alpha_c};
        mul_b = prod_r[MUL_W-1:0];
      end
      S_M3: begin
        mul_a = {24'b0, alpha_inv};
        mul_b = {dterm_r[DTERM_W-1], dterm_r};
      end
      S_M4: begin
        mul_a = {24'b0, kp_of(zone_r)};
        mul_b = {{11{de1_r[ERR_W]}}, de1_r};
      end
      S_M5: begin
        mul_a = {28'b0, ki_of(zone_r)};
        mul_b = {{12{e_r[ERR_W-1]}}, e_r};
      end
      S_SPLIT, S_DONE: begin
        mul_a = {3'b0, power_now_r, 2'b10};
        mul_b = RECIP5;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic [PWR_W-1:0] pm_c, pb_c;
  logic             out_load;

  assign pm_c     = prod_r[32 +: PWR_W];
  assign pb_c     = power_now_r - pm_c;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= TARGET_RST;
      start_power_r <= START_POWER_RST;
      step_limit_r  <= STEP_LIMIT_RST;
      min_power_r   <= MIN_POWER_RST;
      alpha_r       <= ALPHA_RST;
      rot_enable_r  <= ROT_ENABLE_RST;
      rot_suspend_r <= ROT_SUSPEND_RST;
      rot_need_r    <= ROT_NEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TARGET_TEMP: target_r      <= cfg_wdata[TEMP_W-1:0];
        CFG_START_POWER: start_power_r <= cfg_wdata[PWR_W-1:0];
        CFG_STEP_LIMIT:  step_limit_r  <= cfg_wdata[LIM_W-1:0];
        CFG_MIN_POWER:   min_power_r   <= cfg_wdata[PWR_W-1:0];
        CFG_D_ALPHA:     alpha_r       <= cfg_wdata[ALPHA_W-1:0];
        CFG_ROT_ENABLE:  rot_enable_r  <= cfg_wdata[TEMP_W-1:0];
        CFG_ROT_SUSPEND: rot_suspend_r <= cfg_wdata[TEMP_W-1:0];
        CFG_ROT_NEED:    rot_need_r    <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      power_now_r   <= START_POWER_RST;
      err_last_r    <= '0;
      err_before_r  <= '0;
      dterm_r       <= '0;
      has_updated_r <= 1'b0;
      zone_valid_r  <= 1'b0;
      last_zone_r   <= ZONE_COARSE;
      rot_state_r   <= ROT_OFF;
      rot_counter_r <= '0;
      held_ae_r     <= HELD_AE_RST;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            iter_r  <= in_tdata[23:0];
            meas_r  <= in_tdata[43:24];
            av_r    <= in_tuser;
            state_r <= S_GATE;
          end
        end
        S_GATE: begin
          updated_r <= 1'b0;
          clipped_r <= 1'b0;
          zone_r    <= zone_c;
          e_r       <= e_c;
          de1_r     <= de1_c;
          dd_r      <= {de1_c[ERR_W], de1_c} - {de2_c[ERR_W], de2_c};
          if (gate5_c) begin
            held_ae_r <= ae_c;
          end else begin
            zone_r <= zone_valid_r ? last_zone_r : ZONE_COARSE;
          end
          state_r <= do_pid_c ? S_M1 : S_SPLIT;
        end
        S_M1: state_r <= S_M2;
        S_M2: state_r <= S_M3;
        S_M3: begin
          acc_r   <= prod_lo;
          state_r <= S_M4;
        end
        S_M4: begin
          td_r    <= td_full[DTERM_W-1:0];
          acc_r   <= {{(ACC_W-DTERM_W){td_full[DTERM_W-1]}}, td_full[DTERM_W-1:0]};
          state_r <= S_M5;
        end
        S_M5: begin
          acc_r   <= acc_sum;
          state_r <= S_M6;
        end
        S_M6: begin
          acc_r   <= acc_sum;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          power_now_r   <= np_c;
          err_before_r  <= has_updated_r ? err_last_r : e_r;
          err_last_r    <= e_r;
          dterm_r       <= td_r;
          has_updated_r <= 1'b1;
          zone_valid_r  <= 1'b1;
          last_zone_r   <= zone_r;
          updated_r     <= 1'b1;
          clipped_r     <= clip_c;
          if (rot_state_r == ROT_ON) begin
            if (held_ae_r > rot_suspend_r) begin
              rot_state_r   <= ROT_SUSPEND;
              rot_counter_r <= '0;
            end
          end else if (held_ae_r < rot_enable_r) begin
            if (cnt_inc >= {1'b0, rot_need_r}) begin
              rot_state_r   <= ROT_ON;
              rot_counter_r <= rot_need_r;
            end else begin
              rot_counter_r <= cnt_inc[CNT_W-1:0];
            end
          end else begin
            rot_counter_r <= '0;
          end
          state_r <= S_SPLIT;
        end
        S_SPLIT: state_r <= S_DONE;
        S_DONE: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tuser_r <= updated_r;
      out_tdata_r <= {3'b0, held_ae_r, rot_counter_r, rot_state_r, clipped_r, zone_r,
                      pb_c, pm_c, power_now_r};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gsip_pkg::*;

  typedef struct packed {
    logic              upd;
    logic [PWR_W-1:0]  p_tot;
    logic [PWR_W-1:0]  p_main;
    logic [PWR_W-1:0]  p_bot;
    logic [ZONE_W-1:0] zone;
    logic              clip;
    logic [ROT_W-1:0]  rot;
    logic [CNT_W-1:0]  cnt;
    logic [TEMP_W-1:0] ae;
  } heater_out_t;

  typedef struct {
    bit                is_cfg;
    logic [CFG_AW-1:0] idx;
    logic [CFG_DW-1:0] val;
    logic [ITER_W-1:0] iter;
    logic [TEMP_W-1:0] temp;
    logic              av;
    bit                known;
    heater_out_t       want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [47:0]        in_tdata = '0;   // iteration[23:0], measured_temp[43:24], zero pad
  logic               in_tuser = 1'b0; // area_valid
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [119:0]       out_tdata;       // power_total[27:0], power_main[55:28],
                                       // power_bottom[83:56], gain_zone[85:84],
                                       // step_clipped[86], rotation_mode[88:87],
                                       // stable_count[96:89], abs_error[116:97], zero pad
  logic               out_tuser;       // updated
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;

  gain_scheduled_incremental_pid_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("gain_scheduled_incremental_pid_unit regression: fail");
    $finish;
  end

  // controller registers and state as the block should hold them
  logic [TEMP_W-1:0]  tgt       = TARGET_RST;
  logic [PWR_W-1:0]   start_pwr = START_POWER_RST;
  logic [LIM_W-1:0]   step_lim  = STEP_LIMIT_RST;
  logic [PWR_W-1:0]   floor_pwr = MIN_POWER_RST;
  logic [ALPHA_W-1:0] alpha     = ALPHA_RST;
  logic [TEMP_W-1:0]  rot_en    = ROT_ENABLE_RST;
  logic [TEMP_W-1:0]  rot_susp  = ROT_SUSPEND_RST;
  logic [CNT_W-1:0]   rot_need  = ROT_NEED_RST;

  longint             pwr       = longint'(START_POWER_RST);
  longint             err1      = 0;
  longint             err2      = 0;
  longint             d_filt    = 0;
  bit                 has_upd   = 1'b0;
  bit                 zone_ok   = 1'b0;
  logic [ZONE_W-1:0]  zone_held = ZONE_COARSE;
  logic [ROT_W-1:0]   rot_st    = ROT_OFF;
  int                 rot_cnt   = 0;
  logic [TEMP_W-1:0]  held_ae   = HELD_AE_RST;

  longint kp_gain [4] = '{400, 500, 400, 150};
  longint ki_gain [4] = '{15, 20, 12, 5};
  longint kd_gain [4] = '{30, 60, 80, 40};

  heater_out_t pending_heater_out [$];

  int err_count    = 0;
  int results_seen = 0;
  int items_in     = 0;
  int n_updates    = 0;
  int n_clipped    = 0;
  int n_rot_on     = 0;
  int n_suspended  = 0;
  int zone_hits [4] = '{0, 0, 0, 0};
  bit held_off     = 1'b0;

  function automatic longint div_round_up(input longint x, input longint d);
    longint y;
    y = x + d / 2;
    if (y >= 0) return y / d;
    return -((-y + d - 1) / d);
  endfunction

  function automatic heater_out_t predict_heater(input logic [ITER_W-1:0] iter,
                                                 input logic [TEMP_W-1:0] temp,
                                                 input logic av);
    longint e, ae, de1, de2, draw, dterm, dsum, dstep, np, a, lim, pm;
    logic [ZONE_W-1:0] z, zout;
    bit upd, clip;
    int c;
    heater_out_t r;
    upd  = 1'b0;
    clip = 1'b0;
    zout = zone_ok ? zone_held : ZONE_COARSE;
    if (iter != 0 && iter % 5 == 0) begin
      e  = av ? (longint'(tgt) - longint'(temp)) : 0;
      ae = (e < 0) ? -e : e;
      if (!zone_ok) begin
        if (ae > longint'(T_Z1))      z = ZONE_COARSE;
        else if (ae > longint'(T_Z2)) z = ZONE_TRANSITION;
        else if (ae > longint'(T_Z3)) z = ZONE_FINE;
        else                          z = ZONE_PRECISION;
      end else begin
        case (zone_held)
          ZONE_COARSE: z = (ae <= longint'(T_Z1)) ? ZONE_TRANSITION : ZONE_COARSE;
          ZONE_TRANSITION: begin
            if (ae > longint'(T_Z1H))      z = ZONE_COARSE;
            else if (ae <= longint'(T_Z2)) z = ZONE_FINE;
            else                           z = ZONE_TRANSITION;
          end
          ZONE_FINE: begin
            if (ae > longint'(T_Z2H))      z = ZONE_TRANSITION;
            else if (ae <= longint'(T_Z3)) z = ZONE_PRECISION;
            else                           z = ZONE_FINE;
          end
          default: z = (ae > longint'(T_Z3H)) ? ZONE_FINE : ZONE_PRECISION;
        endcase
      end
      held_ae = TEMP_W'(ae);
      zout    = z;
      if (iter % ((z == ZONE_PRECISION) ? 5 : 10) == 0 && av) begin
        a   = (alpha > ALPHA_ONE) ? 256 : longint'(alpha);
        lim = longint'(step_lim);
        if (!has_upd) begin
          err1 = e;
          err2 = e;
        end
        de1   = e - err1;
        de2   = err1 - err2;
        draw  = kd_gain[z] * (de1 - de2);
        dterm = div_round_up(a * draw + (256 - a) * d_filt, 256);
        dsum  = kp_gain[z] * de1 + ki_gain[z] * e + dterm;
        if (dsum > lim * 16) begin
          dstep = lim;
          clip  = 1'b1;
        end else if (dsum < -lim * 16) begin
          dstep = -lim;
          clip  = 1'b1;
        end else begin
          dstep = div_round_up(dsum, 16);
        end
        np = pwr + dstep;
        if (np < longint'(floor_pwr)) np = longint'(floor_pwr);
        if (np > longint'(P_MAX)) np = longint'(P_MAX);
        pwr       = np;
        err2      = err1;
        err1      = e;
        d_filt    = dterm;
        has_upd   = 1'b1;
        zone_held = z;
        zone_ok   = 1'b1;
        upd       = 1'b1;
        if (rot_st == ROT_ON) begin
          if (ae > longint'(rot_susp)) begin
            rot_st  = ROT_SUSPEND;
            rot_cnt = 0;
          end
        end else if (ae < longint'(rot_en)) begin
          c = rot_cnt + 1;
          if (c >= int'(rot_need)) begin
            rot_st = ROT_ON;
            c      = int'(rot_need);
          end
          rot_cnt = c & 255;
        end else begin
          rot_cnt = 0;
        end
      end
    end
    pm       = (4 * pwr + 2) / 5;
    r.upd    = upd;
    r.p_tot  = PWR_W'(pwr);
    r.p_main = PWR_W'(pm);
    r.p_bot  = PWR_W'(pwr - pm);
    r.zone   = zout;
    r.clip   = clip;
    r.rot    = rot_st;
    r.cnt    = CNT_W'(rot_cnt);
    r.ae     = held_ae;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DW-1:0] pick_reg(input logic [CFG_DW-1:0] hi,
                                                 input logic [CFG_DW-1:0] typical);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return hi;
    return typical;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_AW-1:0] idx,
                                        input logic [CFG_DW-1:0] val);
    plan_row_t p;
    p        = '{default: '0};
    p.is_cfg = 1'b1;
    p.idx    = idx;
    p.val    = val;
    return p;
  endfunction

  function automatic plan_row_t beat_row(input logic [ITER_W-1:0] iter,
                                         input logic [TEMP_W-1:0] temp, input logic av);
    plan_row_t p;
    p      = '{default: '0};
    p.iter = iter;
    p.temp = temp;
    p.av   = av;
    return p;
  endfunction

  function automatic plan_row_t known_row(input logic [ITER_W-1:0] iter,
                                          input logic [TEMP_W-1:0] temp, input logic av,
                                          input heater_out_t want);
    plan_row_t p;
    p       = beat_row(iter, temp, av);
    p.known = 1'b1;
    p.want  = want;
    return p;
  endfunction

  task automatic flag_error(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 40)
      $display("ERROR result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TARGET_TEMP: tgt       = val[TEMP_W-1:0];
      CFG_START_POWER: start_pwr = val[PWR_W-1:0];
      CFG_STEP_LIMIT:  step_lim  = val[LIM_W-1:0];
      CFG_MIN_POWER:   floor_pwr = val[PWR_W-1:0];
      CFG_D_ALPHA:     alpha     = val[ALPHA_W-1:0];
      CFG_ROT_ENABLE:  rot_en    = val[TEMP_W-1:0];
      CFG_ROT_SUSPEND: rot_susp  = val[TEMP_W-1:0];
      default:         rot_need  = val[CNT_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_heater_out.size() != 0) @(posedge clk);
  endtask

  task automatic push_beat(input logic [ITER_W-1:0] iter, input logic [TEMP_W-1:0] temp,
                           input logic av, input bit known, input heater_out_t want,
                           input int gap);
    heater_out_t pred;
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, temp, iter};
    in_tuser  <= av;
    do @(posedge clk); while (!in_tready);
    pred = predict_heater(iter, temp, av);
    pending_heater_out.push_back(known ? want : pred);
    items_in++;
  endtask

  always @(posedge clk) begin
    heater_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.upd    = out_tuser;
      got.p_tot  = out_tdata[27:0];
      got.p_main = out_tdata[55:28];
      got.p_bot  = out_tdata[83:56];
      got.zone   = out_tdata[85:84];
      got.clip   = out_tdata[86];
      got.rot    = out_tdata[88:87];
      got.cnt    = out_tdata[96:89];
      got.ae     = out_tdata[116:97];
      results_seen++;
      if (pending_heater_out.size() == 0) begin
        flag_error("result with nothing pending, power_total", got.p_tot, 0);
      end else begin
        want = pending_heater_out.pop_front();
        if (got.upd != want.upd)       flag_error("updated", got.upd, want.upd);
        if (got.p_tot != want.p_tot)   flag_error("power_total", got.p_tot, want.p_tot);
        if (got.p_main != want.p_main) flag_error("power_main", got.p_main, want.p_main);
        if (got.p_bot != want.p_bot)   flag_error("power_bottom", got.p_bot, want.p_bot);
        if (got.zone != want.zone)     flag_error("gain_zone", got.zone, want.zone);
        if (got.clip != want.clip)     flag_error("step_clipped", got.clip, want.clip);
        if (got.rot != want.rot)       flag_error("rotation_mode", got.rot, want.rot);
        if (got.cnt != want.cnt)       flag_error("stable_count", got.cnt, want.cnt);
        if (got.ae != want.ae)         flag_error("abs_error", got.ae, want.ae);
      end
      if (got.upd) n_updates++;
      if (got.clip) n_clipped++;
      if (got.rot == ROT_ON) n_rot_on++;
      if (got.rot == ROT_SUSPEND) n_suspended++;
      zone_hits[got.zone]++;
    end
  end

  initial begin
    int run, stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 400) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        held_off = 1'b1;
      end
      out_tready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    heater_out_t idle_out, w;
    heater_out_t none;
    logic [ITER_W-1:0] iter_ctr, iter_val;
    longint err, t;
    int random_items, len, mode, r, sel;
    bit quiet;
    logic av;

    none     = '0;
    idle_out = '{upd: 1'b0, p_tot: 28'd4000000, p_main: 28'd3200000, p_bot: 28'd800000,
                 zone: ZONE_COARSE, clip: 1'b0, rot: ROT_OFF, cnt: 8'd0, ae: 20'd255744};

    plan.push_back(known_row(24'd0, 20'd431360, 1'b1, idle_out));
    plan.push_back(known_row(24'd3, 20'd0, 1'b1, idle_out));
    w = idle_out;
    w.zone = ZONE_PRECISION;
    w.ae   = 20'd0;
    plan.push_back(known_row(24'd5, 20'hFFFFF, 1'b0, w));
    w.zone = ZONE_COARSE;
    w.ae   = 20'd431360;
    plan.push_back(known_row(24'd15, 20'd0, 1'b1, w));
    w = '{upd: 1'b1, p_tot: 28'd4080000, p_main: 28'd3264000, p_bot: 28'd816000,
          zone: ZONE_COARSE, clip: 1'b1, rot: ROT_OFF, cnt: 8'd0, ae: 20'd431360};
    plan.push_back(known_row(24'd20, 20'd0, 1'b1, w));
    plan.push_back(beat_row(24'd30, 20'hFFFFF, 1'b1));
    plan.push_back(beat_row(24'd40, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd50, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd60, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd65, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd70, 20'd432360, 1'b1));
    plan.push_back(beat_row(24'd75, 20'd432960, 1'b1));
    plan.push_back(beat_row(24'd80, 20'd429960, 1'b1));
    plan.push_back(beat_row(24'hFFFFFF, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd16777210, 20'd0, 1'b1));
    plan.push_back(cfg_row(CFG_D_ALPHA, 28'd511));
    plan.push_back(beat_row(24'd20, 20'd434360, 1'b1));
    plan.push_back(cfg_row(CFG_ROT_NEED, 28'd3));
    plan.push_back(beat_row(24'd30, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd35, 20'd431360, 1'b1));
    plan.push_back(cfg_row(CFG_ROT_NEED, 28'd1));
    plan.push_back(beat_row(24'd40, 20'd431360, 1'b1));
    plan.push_back(beat_row(24'd50, 20'd0, 1'b1));
    plan.push_back(cfg_row(CFG_MIN_POWER, 28'hFFFFFFF));
    plan.push_back(beat_row(24'd60, 20'd431360, 1'b1));
    plan.push_back(cfg_row(CFG_TARGET_TEMP, 28'hFFFFF));
    plan.push_back(beat_row(24'd70, 20'd0, 1'b1));
    plan.push_back(cfg_row(CFG_TARGET_TEMP, 28'd0));
    plan.push_back(beat_row(24'd80, 20'hFFFFF, 1'b1));
    plan.push_back(cfg_row(CFG_MIN_POWER, 28'd0));
    plan.push_back(beat_row(24'd90, 20'd0, 1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        set_reg(plan[i].idx, plan[i].val);
      end else begin
        push_beat(plan[i].iter, plan[i].temp, plan[i].av, plan[i].known, plan[i].want,
                  gap_len());
      end
    end

    random_items = 0;
    iter_ctr     = 24'd100;
    err          = 0;
    while (random_items < 1350) begin
      settle();
      set_reg(CFG_TARGET_TEMP, pick_reg(28'hFFFFF, $urandom_range(380000, 480000)));
      set_reg(CFG_START_POWER, pick_reg(28'hFFFFFFF, $urandom & 28'hFFFFFFF));
      set_reg(CFG_STEP_LIMIT, pick_reg(28'hFFFFFF, $urandom_range(1000, 200000)));
      set_reg(CFG_MIN_POWER, pick_reg(28'hFFFFFFF, $urandom_range(0, 2000000)));
      set_reg(CFG_D_ALPHA, pick_reg(28'd511,
                                    ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(0, 300)));
      set_reg(CFG_ROT_ENABLE, pick_reg(28'hFFFFF, $urandom_range(500, 6000)));
      set_reg(CFG_ROT_SUSPEND, pick_reg(28'hFFFFF, $urandom_range(3000, 30000)));
      set_reg(CFG_ROT_NEED, pick_reg(28'd255,
                                     ($urandom_range(0, 3) == 0) ? 50 : $urandom_range(1, 12)));

      len   = $urandom_range(20, 80);
      quiet = ($urandom_range(0, 3) == 0);
      r     = $urandom_range(0, 99);
      mode  = (r < 35) ? 0 : (r < 65) ? 1 : (r < 85) ? 2 : 3;
      err   = $urandom_range(0, 60000);
      if ($urandom_range(0, 1)) err = -err;

      for (int i = 0; i < len; i++) begin
        case (mode)
          0: err = err * 7 / 8 + $urandom_range(0, 400) - 200;
          1: err = longint'($urandom_range(0, 6000)) - 3000;
          2: begin
            sel = $urandom_range(0, 2);
            err = (sel == 0) ? longint'(T_Z1) : (sel == 1) ? longint'(T_Z2) : longint'(T_Z3);
            err = err + $urandom_range(0, 262) - 3;
            if ($urandom_range(0, 1)) err = -err;
          end
          default: err = longint'(tgt) - longint'($urandom & 32'hFFFFF);
        endcase
        t = longint'(tgt) - err;
        if (t < 0) t = 0;
        if (t > 1048575) t = 1048575;

        r = $urandom_range(0, 19);
        if (r < 9)       iter_ctr = iter_ctr + 10;
        else if (r < 15) iter_ctr = iter_ctr + 5;
        else if (r < 17) iter_ctr = iter_ctr + $urandom_range(1, 4);
        else if (r == 17) begin
          iter_ctr = $urandom;
          if ($urandom_range(0, 1)) iter_ctr = iter_ctr - iter_ctr % 10;
        end else if (r == 19) iter_ctr = iter_ctr + 5;
        iter_val = (r == 18) ? '0 : iter_ctr;
        av       = ($urandom_range(0, 19) != 0);

        push_beat(iter_val, TEMP_W'(t), av, 1'b0, none, quiet ? 0 : gap_len());
        random_items++;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d beats in, %0d results out, %0d PID updates, %0d clipped steps",
             items_in, results_seen, n_updates, n_clipped);
    $display("rotation on in %0d results, suspended in %0d; zones seen %0d/%0d/%0d/%0d",
             n_rot_on, n_suspended, zone_hits[0], zone_hits[1], zone_hits[2], zone_hits[3]);
    if (err_count == 0) begin
      $display("gain_scheduled_incremental_pid_unit regression: pass");
    end else begin
      $display("gain_scheduled_incremental_pid_unit regression: fail");
    end
    $finish;
  end

endmodule
